[hw/rtl/drht_pkg.sv]
// ----------------------------------------------------------------------------
// drht_pkg
// Shared types, sizes and helpers for the dirty range history tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package drht_pkg;

	localparam int HIST_DEPTH = 16;
	localparam int IDX_BITS   = 24;

	localparam int FIRST_W = IDX_BITS;
	localparam int COUNT_W = IDX_BITS + 1;
	localparam int END_W   = IDX_BITS + 2;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = $clog2(HIST_DEPTH);
	localparam int FILL_W  = $clog2(HIST_DEPTH + 1);
	localparam int SUM_W   = FILL_W + 1;

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [FIRST_W-1:0] first;
		logic [COUNT_W-1:0] count;
		logic               full;
	} entry_t;

	typedef struct packed {
		logic load;
		logic write;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic quick;
		logic scan_last;
	} sts_t;

	function automatic logic [SLOT_W-1:0] ring_slot(input logic [SLOT_W-1:0] base,
			input logic [FILL_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(HIST_DEPTH)) begin
			sum = sum - SUM_W'(HIST_DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/drht_ctrl.sv]
// ----------------------------------------------------------------------------
// drht_ctrl
// Sequencer that steps a request through decode, history scan and result.
// ----------------------------------------------------------------------------
`default_nettype none

module drht_ctrl
	import drht_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!sts.is_query || sts.quick) begin
					state_next = ST_RESULT;
				end else begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_next = ST_RESULT;
			ST_RESULT: state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		busy          = 1'b1;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DECIDE: cmd.write     = !sts.is_query;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_DRAIN:  cmd           = '0;
			ST_RESULT: cmd.emit      = 1'b1;
			default:   cmd           = '0;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/drht_dp.sv]
// ----------------------------------------------------------------------------
// drht_dp
// Request registers, history ring memory, scan evaluation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module drht_dp
	import drht_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  wire                req_type,
	input  wire                clear_first,
	input  wire  [FIRST_W-1:0] range_first,
	input  wire  [COUNT_W-1:0] range_count,
	input  wire                full_flag,
	input  wire  [STAMP_W-1:0] stamp,
	input  wire  [STAMP_W-1:0] since_time,
	input  wire  [COUNT_W-1:0] inst_total,
	output logic               done,
	output logic [FIRST_W-1:0] out_first,
	output logic [COUNT_W-1:0] out_count,
	output logic               out_full
);

	logic               req_q;
	logic               clear_q;
	logic [FIRST_W-1:0] first_q;
	logic [COUNT_W-1:0] count_q;
	logic               flag_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] since_q;
	logic [COUNT_W-1:0] inst_q;

	logic [SLOT_W-1:0]  oldest_q;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  k_q;

	entry_t             mem [HIST_DEPTH];
	entry_t             rd_s1;
	logic               rd_v_s1;
	logic               first_s1;
	logic               last_s1;

	logic               found_q;
	logic               force_q;
	logic [FIRST_W-1:0] lo_q;
	logic [END_W-1:0]   hi_q;

	logic               done_q;
	logic [FIRST_W-1:0] res_first_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               res_full_q;

	logic [SLOT_W-1:0]  eff_old;
	logic [FILL_W-1:0]  eff_fill;
	logic               ring_full;
	logic [SLOT_W-1:0]  wr_slot;
	logic [SLOT_W-1:0]  rd_addr;
	logic               newer;
	logic [END_W-1:0]   rd_end;
	logic               hit_full;
	logic [END_W-1:0]   hull_len;
	logic               empty_ans;
	logic               full_ans;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			clear_q <= clear_first;
			first_q <= range_first;
			count_q <= range_count;
			flag_q  <= full_flag;
			now_q   <= stamp;
			since_q <= since_time;
			inst_q  <= inst_total;
		end
	end

	assign eff_old   = clear_q ? '0 : oldest_q;
	assign eff_fill  = clear_q ? '0 : fill_q;
	assign ring_full = (eff_fill == FILL_W'(HIST_DEPTH));
	assign wr_slot   = ring_full ? eff_old : ring_slot(eff_old, eff_fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
		end else if (cmd.write) begin
			if (ring_full) begin
				oldest_q <= ring_slot(eff_old, FILL_W'(1));
				fill_q   <= eff_fill;
			end else begin
				oldest_q <= eff_old;
				fill_q   <= eff_fill + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_slot] <= '{stamp: now_q, first: first_q, count: count_q, full: flag_q};
		end
	end

	assign rd_addr = ring_slot(oldest_q, k_q);

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_s1    <= mem[rd_addr];
			first_s1 <= (k_q == '0);
			last_s1  <= sts.scan_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_step;
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.scan_step) begin
				k_q <= k_q + FILL_W'(1);
			end
		end
	end

	assign newer    = (rd_s1.stamp > since_q);
	assign rd_end   = END_W'(rd_s1.first) + END_W'(rd_s1.count);
	assign hit_full = (last_s1 && (rd_s1.stamp != now_q))
		|| (first_s1 && (fill_q == FILL_W'(HIST_DEPTH)) && (since_q < rd_s1.stamp))
		|| (newer && rd_s1.full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			force_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
			force_q <= 1'b0;
		end else if (rd_v_s1) begin
			if (hit_full) begin
				force_q <= 1'b1;
			end
			if (newer && !rd_s1.full) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1 && newer && !rd_s1.full) begin
			if (!found_q) begin
				lo_q <= rd_s1.first;
				hi_q <= rd_end;
			end else begin
				if (rd_s1.first < lo_q) begin
					lo_q <= rd_s1.first;
				end
				if (rd_end > hi_q) begin
					hi_q <= rd_end;
				end
			end
		end
	end

	assign empty_ans = (since_q >= now_q);
	assign full_ans  = (since_q == '0) || (fill_q == '0) || force_q || !found_q;
	assign hull_len  = hi_q - END_W'(lo_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if ((req_q == REQ_RECORD) || empty_ans) begin
				res_first_q <= '0;
				res_count_q <= '0;
				res_full_q  <= 1'b0;
			end else if (full_ans) begin
				res_first_q <= '0;
				res_count_q <= inst_q;
				res_full_q  <= 1'b1;
			end else begin
				res_first_q <= lo_q;
				res_count_q <= hull_len[END_W-1] ? '1 : hull_len[COUNT_W-1:0];
				res_full_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign sts.is_query  = (req_q == REQ_QUERY);
	assign sts.quick     = empty_ans || (since_q == '0) || (fill_q == '0);
	assign sts.scan_last = (k_q == (fill_q - FILL_W'(1)));

	assign done      = done_q;
	assign out_first = res_first_q;
	assign out_count = res_count_q;
	assign out_full  = res_full_q;

endmodule

`default_nettype wire

[hw/rtl/dirty_range_history_tracker.sv]
// ----------------------------------------------------------------------------
// dirty_range_history_tracker
// Keeps a ring of dirty range records and answers what changed since a time.
// ----------------------------------------------------------------------------
// A record request passes decide and result; done is registered from result.
// A query scans the valid records, one history memory read per cycle, then
// drains the read stage; a query answered without a scan skips both.
// A new request is taken in the cycle its predecessor's result is shown.
// Reset clears the ring pointers and control; record contents need no reset.
`default_nettype none

module dirty_range_history_tracker
	import drht_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire                req_type,
	input  wire                clear_first,
	input  wire  [FIRST_W-1:0] range_first,
	input  wire  [COUNT_W-1:0] range_count,
	input  wire                full_flag,
	input  wire  [STAMP_W-1:0] stamp,
	input  wire  [STAMP_W-1:0] since_time,
	input  wire  [COUNT_W-1:0] inst_total,
	output logic               done,
	output logic [FIRST_W-1:0] out_first,
	output logic [COUNT_W-1:0] out_count,
	output logic               out_full
);

	cmd_t cmd;
	sts_t sts;

	drht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	drht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.clear_first (clear_first),
		.range_first (range_first),
		.range_count (range_count),
		.full_flag   (full_flag),
		.stamp       (stamp),
		.since_time  (since_time),
		.inst_total  (inst_total),
		.done        (done),
		.out_first   (out_first),
		.out_count   (out_count),
		.out_full    (out_full)
	);

endmodule

`default_nettype wire

[hw/rtl/drht_chk.sv]
// ----------------------------------------------------------------------------
// drht_chk
// Port level checks for the dirty range history tracker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module drht_chk
	import drht_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire               done,
	input wire [FIRST_W-1:0] out_first,
	input wire               out_full
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not make the block busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_full_first: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_full) |-> (out_first == '0))
		else $error("full answer with nonzero first index");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

endmodule

bind dirty_range_history_tracker drht_chk u_chk (.*);

`default_nettype wire

[test/dirty_range_history_tracker_tb.sv]
// ----------------------------------------------------------------------------
// dirty_range_history_tracker_tb
// Self-checking bench for the dirty range history tracker. A short table of
// directed requests is followed by random record bursts and queries. Every
// result word is checked against its pinned answer or the bench's ring model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dirty_range_history_tracker_tb;
	import drht_pkg::*;

	localparam int TOTAL_WORDS    = 1900;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 25;
	localparam logic [COUNT_W-1:0] COUNT_ALL = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_TOP = 25'h1000000;

	typedef struct packed {
		logic               req_type;
		logic               clear_first;
		logic [FIRST_W-1:0] range_first;
		logic [COUNT_W-1:0] range_count;
		logic               full_flag;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] since_time;
		logic [COUNT_W-1:0] inst_total;
	} request_t;

	typedef struct packed {
		logic [FIRST_W-1:0] first;
		logic [COUNT_W-1:0] count;
		logic               full;
	} answer_t;

	typedef struct packed {
		request_t rq;
		logic     pinned;
		answer_t  ans;
	} directed_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               req_type;
	logic               clear_first;
	logic [FIRST_W-1:0] range_first;
	logic [COUNT_W-1:0] range_count;
	logic               full_flag;
	logic [STAMP_W-1:0] stamp;
	logic [STAMP_W-1:0] since_time;
	logic [COUNT_W-1:0] inst_total;
	logic               done;
	logic [FIRST_W-1:0] out_first;
	logic [COUNT_W-1:0] out_count;
	logic               out_full;

	logic [STAMP_W-1:0] ring_stamp [HIST_DEPTH];
	logic [FIRST_W-1:0] ring_first [HIST_DEPTH];
	logic [COUNT_W-1:0] ring_count [HIST_DEPTH];
	logic               ring_full  [HIST_DEPTH];
	int                 ring_oldest;
	int                 ring_fill;

	answer_t       pending_answers [$];
	directed_row_t dir_table [$];
	logic          cur_pinned;
	answer_t       cur_pin_ans;
	request_t      seen_req;
	answer_t       predicted_ans;
	answer_t       got_ans;
	answer_t       want_ans;

	int  fail_count;
	int  idle_cycles;
	int  n_sent;
	int  n_records;
	int  n_queries;
	int  n_full_answers;
	int  n_hull_answers;
	int  n_empty_answers;
	int  n_overwrites;
	bit  idle_enable;

	dirty_range_history_tracker uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.clear_first (clear_first),
		.range_first (range_first),
		.range_count (range_count),
		.full_flag   (full_flag),
		.stamp       (stamp),
		.since_time  (since_time),
		.inst_total  (inst_total),
		.done        (done),
		.out_first   (out_first),
		.out_count   (out_count),
		.out_full    (out_full)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic track_request(input request_t rq, output answer_t ans);
		int                 slot;
		int                 k;
		logic [END_W-1:0]   lo;
		logic [END_W-1:0]   hi;
		logic [END_W-1:0]   fin;
		logic [END_W-1:0]   len;
		logic               found;
		logic               full_ans;
		logic               is_empty;
		ans = '0;
		lo = '0;
		hi = '0;
		found = 1'b0;
		full_ans = 1'b0;
		is_empty = 1'b0;
		if (rq.req_type == REQ_RECORD) begin
			n_records++;
			if (rq.clear_first) begin
				ring_oldest = 0;
				ring_fill = 0;
			end
			if (ring_fill < HIST_DEPTH) begin
				slot = (ring_oldest + ring_fill) % HIST_DEPTH;
				ring_fill++;
			end else begin
				slot = ring_oldest;
				ring_oldest = (ring_oldest + 1) % HIST_DEPTH;
				n_overwrites++;
			end
			ring_stamp[slot] = rq.stamp;
			ring_first[slot] = rq.range_first;
			ring_count[slot] = rq.range_count;
			ring_full[slot] = rq.full_flag;
		end else begin
			n_queries++;
			if (rq.since_time >= rq.stamp) begin
				is_empty = 1'b1;
			end else if (rq.since_time == '0 || ring_fill == 0) begin
				full_ans = 1'b1;
			end else if (ring_stamp[(ring_oldest + ring_fill - 1) % HIST_DEPTH] != rq.stamp) begin
				full_ans = 1'b1;
			end else if (ring_fill == HIST_DEPTH && rq.since_time < ring_stamp[ring_oldest]) begin
				full_ans = 1'b1;
			end else begin
				for (k = 0; k < ring_fill; k++) begin
					slot = (ring_oldest + k) % HIST_DEPTH;
					if (ring_stamp[slot] > rq.since_time && !full_ans) begin
						if (ring_full[slot]) begin
							full_ans = 1'b1;
						end else begin
							fin = END_W'(ring_first[slot]) + END_W'(ring_count[slot]);
							if (!found || END_W'(ring_first[slot]) < lo) begin
								lo = END_W'(ring_first[slot]);
							end
							if (!found || fin > hi) begin
								hi = fin;
							end
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					full_ans = 1'b1;
				end
			end
			if (full_ans) begin
				n_full_answers++;
				ans.count = rq.inst_total;
				ans.full = 1'b1;
			end else if (is_empty) begin
				n_empty_answers++;
			end else begin
				n_hull_answers++;
				len = hi - lo;
				if (len > END_W'(COUNT_ALL)) begin
					len = END_W'(COUNT_ALL);
				end
				ans.first = lo[FIRST_W-1:0];
				ans.count = len[COUNT_W-1:0];
			end
		end
	endtask

	function automatic directed_row_t mk_row(input logic rt, input logic cf,
			input logic [FIRST_W-1:0] rf, input logic [COUNT_W-1:0] rc, input logic ff,
			input logic [STAMP_W-1:0] st, input logic [STAMP_W-1:0] sn,
			input logic [COUNT_W-1:0] ic, input logic pin, input logic [FIRST_W-1:0] ef,
			input logic [COUNT_W-1:0] ec, input logic efl);
		directed_row_t row;
		row.rq = {rt, cf, rf, rc, ff, st, sn, ic};
		row.pinned = pin;
		row.ans = {ef, ec, efl};
		return row;
	endfunction

	function automatic logic [FIRST_W-1:0] pick_first();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return {FIRST_W{1'b1}};
			end
			2, 3: begin
				return FIRST_W'($urandom);
			end
			default: begin
				return FIRST_W'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return COUNT_TOP;
			end
			2, 3: begin
				return COUNT_W'($urandom_range(0, 24'hFFFFFF));
			end
			default: begin
				return COUNT_W'($urandom_range(0, 64));
			end
		endcase
	endfunction

	task automatic issue_word(input request_t rq, input logic pin, input answer_t pin_ans);
		while (idle_enable && $urandom_range(0, 99) < 16) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req_type <= rq.req_type;
		clear_first <= rq.clear_first;
		range_first <= rq.range_first;
		range_count <= rq.range_count;
		full_flag <= rq.full_flag;
		stamp <= rq.stamp;
		since_time <= rq.since_time;
		inst_total <= rq.inst_total;
		cur_pinned <= pin;
		cur_pin_ans <= pin_ans;
		do begin
			@(posedge clk);
		end while (busy);
		n_sent++;
	endtask

	task automatic drain_answers();
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				seen_req = {req_type, clear_first, range_first, range_count, full_flag,
					stamp, since_time, inst_total};
				track_request(seen_req, predicted_ans);
				pending_answers.push_back(cur_pinned ? cur_pin_ans : predicted_ans);
			end
			if (done) begin
				got_ans = {out_first, out_count, out_full};
				if (pending_answers.size() == 0) begin
					$error("result word with no request waiting");
					fail_count++;
				end else begin
					want_ans = pending_answers.pop_front();
					if (got_ans.first !== want_ans.first) begin
						$error("out_first: expected %0h, got %0h", want_ans.first, got_ans.first);
						fail_count++;
					end
					if (got_ans.count !== want_ans.count) begin
						$error("out_count: expected %0h, got %0h", want_ans.count, got_ans.count);
						fail_count++;
					end
					if (got_ans.full !== want_ans.full) begin
						$error("out_full: expected %0h, got %0h", want_ans.full, got_ans.full);
						fail_count++;
					end
				end
			end
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		request_t           rq;
		answer_t            no_pin;
		logic [STAMP_W-1:0] now_t;
		bit                 pressure_done;
		int                 i;
		int                 mode;
		int                 n_rec;
		int                 n_qry;
		int                 j;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_RECORD;
		clear_first = 1'b0;
		range_first = '0;
		range_count = '0;
		full_flag = 1'b0;
		stamp = '0;
		since_time = '0;
		inst_total = '0;
		cur_pinned = 1'b0;
		cur_pin_ans = '0;
		no_pin = '0;
		ring_oldest = 0;
		ring_fill = 0;
		fail_count = 0;
		idle_cycles = 0;
		n_sent = 0;
		n_records = 0;
		n_queries = 0;
		n_full_answers = 0;
		n_hull_answers = 0;
		n_empty_answers = 0;
		n_overwrites = 0;
		idle_enable = 1'b1;
		pressure_done = 1'b0;

		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd10, 32'd5, 25'd100,
			1, 0, 25'd100, 1));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd10, 32'd10, 25'd100,
			1, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd0, 32'hFFFFFFFF, 25'd100,
			1, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_RECORD, 1, 0, 0, 0, 32'd100, 0, 0, 1, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_RECORD, 0, 24'hFFFFFF, COUNT_TOP, 0, 32'd200, 0, 0,
			1, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd200, 32'd150, 25'd7,
			0, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd200, 32'd50, 25'd7,
			0, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd200, 32'd0, COUNT_TOP,
			1, 0, COUNT_TOP, 1));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd300, 32'd150, 25'h0ABCDE,
			1, 0, 25'h0ABCDE, 1));
		dir_table.push_back(mk_row(REQ_RECORD, 0, 24'd5, 25'd5, 1, 32'd400, 0, 0,
			1, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd400, 32'd300, 25'd9,
			1, 0, 25'd9, 1));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd400, 32'd100, 25'd9,
			1, 0, 25'd9, 1));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd400, 32'd399, 25'd9,
			1, 0, 25'd9, 1));
		dir_table.push_back(mk_row(REQ_RECORD, 1, 24'd20, 25'd3, 0, 32'd500, 0, 0,
			1, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_RECORD, 0, 24'd8, 25'd4, 0, 32'd500, 0, 0,
			1, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd500, 32'd1, 25'd3,
			0, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'd500, 32'd499, 25'd3,
			0, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 1, 24'hFFFFFF, COUNT_ALL, 1, 32'd500,
			32'd2, 25'd11, 0, 0, 0, 0));
		dir_table.push_back(mk_row(REQ_QUERY, 0, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF,
			COUNT_TOP, 1, 0, 0, 0));

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < dir_table.size(); i++) begin
			issue_word(dir_table[i].rq, dir_table[i].pinned, dir_table[i].ans);
		end

		now_t = 32'd1000;
		while (n_sent < TOTAL_WORDS) begin
			idle_enable = !(n_sent >= 600 && n_sent < 1000);
			if (!pressure_done && n_sent >= 1200) begin
				drain_answers();
				pressure_done = 1'b1;
			end
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				rq.req_type = 1'($urandom_range(0, 1));
				rq.clear_first = 1'($urandom_range(0, 1));
				rq.range_first = FIRST_W'($urandom);
				rq.range_count = pick_count();
				rq.full_flag = 1'($urandom_range(0, 1));
				rq.stamp = $urandom;
				rq.since_time = $urandom;
				rq.inst_total = pick_count();
				issue_word(rq, 1'b0, no_pin);
			end else begin
				if (mode == 1) begin
					now_t = $urandom_range(1, 32'hFFFFFF00);
				end
				n_rec = $urandom_range(1, 20);
				for (j = 0; j < n_rec; j++) begin
					now_t = now_t + $urandom_range(0, 3);
					rq = '0;
					rq.req_type = REQ_RECORD;
					rq.clear_first = ($urandom_range(0, 15) == 0);
					rq.range_first = pick_first();
					rq.range_count = pick_count();
					rq.full_flag = ($urandom_range(0, 11) == 0);
					rq.stamp = now_t;
					rq.since_time = $urandom;
					rq.inst_total = pick_count();
					issue_word(rq, 1'b0, no_pin);
				end
				n_qry = $urandom_range(1, 4);
				for (j = 0; j < n_qry; j++) begin
					rq.req_type = REQ_QUERY;
					rq.clear_first = 1'($urandom_range(0, 1));
					rq.range_first = FIRST_W'($urandom);
					rq.range_count = pick_count();
					rq.full_flag = 1'($urandom_range(0, 1));
					rq.stamp = ($urandom_range(0, 7) == 0) ? now_t + 1 : now_t;
					rq.inst_total = pick_count();
					case ($urandom_range(0, 7))
						0: begin
							rq.since_time = '0;
						end
						1: begin
							rq.since_time = $urandom_range(now_t, 32'hFFFFFFFF);
						end
						2: begin
							rq.since_time = (ring_fill == 0) ? $urandom :
								ring_stamp[ring_oldest] - $urandom_range(1, 3);
						end
						default: begin
							rq.since_time = (ring_fill == 0) ? $urandom :
								ring_stamp[(ring_oldest + $urandom_range(0, ring_fill - 1))
								% HIST_DEPTH] - $urandom_range(0, 1);
						end
					endcase
					issue_word(rq, 1'b0, no_pin);
				end
			end
		end

		drain_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d records (%0d overwrote the oldest) and %0d queries.",
			n_records, n_overwrites, n_queries);
		$display("Queries gave %0d full, %0d hull and %0d empty answers.",
			n_full_answers, n_hull_answers, n_empty_answers);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
